// ===== rtl/core/crp_pkg.sv =====
// ----------------------------------------------------------------------------
// crp_pkg: shared types and constants for the cell reference parser
// Character classes, the queue word format, limits and register indexes.
// ----------------------------------------------------------------------------
package crp_pkg;

  localparam int ROW_W = 21;
  localparam int COL_W = 15;

  localparam logic [ROW_W-1:0] ROW_MAX_LIMIT = 21'd1048576;
  localparam logic [COL_W-1:0] COL_MAX_LIMIT = 15'd16384;
  localparam logic [ROW_W-1:0] ROW_SAT       = 21'd1048577;
  localparam logic [COL_W-1:0] COL_SAT       = 15'd16385;

  localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register word index (paddr[2])
  localparam logic REG_ROW_LIMIT = 1'b0;
  localparam logic REG_COL_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_DOLLAR,
    CLS_LETTER,
    CLS_DIGIT,
    CLS_OTHER
  } char_class_t;

  // classified word: letter value 1..26 or digit value 0..9
  typedef struct packed {
    char_class_t cls;
    logic [4:0]  value;
    logic        last;
  } word_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== rtl/core/crp_front.sv =====
// ----------------------------------------------------------------------------
// crp_front: input handshake and character classification
// Turns each accepted character into a class and a small value for the queue.
// ----------------------------------------------------------------------------
module crp_front import crp_pkg::*; (
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_char_code,
  input  logic          in_char_present,
  input  logic          in_last_char,
  input  queue_status_t q_status,
  output logic          q_push,
  output word_t         q_wdata
);

  assign in_stall = q_status.full;
  assign q_push   = in_valid && !q_status.full;

  always_comb begin
    q_wdata.last  = in_last_char;
    q_wdata.value = 5'd0;
    if (!in_char_present) begin
      q_wdata.cls = CLS_NONE;
    end else if (in_char_code == CHAR_DOLLAR) begin
      q_wdata.cls = CLS_DOLLAR;
    end else if (in_char_code inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
      q_wdata.cls   = CLS_LETTER;
      q_wdata.value = 5'(in_char_code - CHAR_UPPER_A + 8'd1);
    end else if (in_char_code inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
      q_wdata.cls   = CLS_LETTER;
      q_wdata.value = 5'(in_char_code - CHAR_LOWER_A + 8'd1);
    end else if (in_char_code inside {[CHAR_ZERO:CHAR_NINE]}) begin
      q_wdata.cls   = CLS_DIGIT;
      q_wdata.value = 5'(in_char_code - CHAR_ZERO);
    end else begin
      q_wdata.cls = CLS_OTHER;
    end
  end

endmodule

// ===== rtl/core/crp_queue.sv =====
// ----------------------------------------------------------------------------
// crp_queue: short word queue between front and back
// Register-based FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module crp_queue import crp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  word_t         wdata,
  input  logic          pop,
  output word_t         head,
  output queue_status_t status
);

  word_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("queue pushed while full");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

// ===== rtl/core/crp_back.sv =====
// ----------------------------------------------------------------------------
// crp_back: parse state, accumulators and result register
// Executes one classified word per cycle while the queue holds words and, for a
// last word, the result register is free; emits a result on the last word.
module crp_back import crp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  word_t            head,
  input  queue_status_t    q_status,
  output logic             q_pop,
  input  logic [ROW_W-1:0] row_limit,
  input  logic [COL_W-1:0] column_limit,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ROW_W-1:0] out_row_number,
  output logic [COL_W-1:0] out_column_number,
  output logic             out_is_valid
);

  logic             row_phase_r, row_phase_nxt;
  logic [COL_W-1:0] col_sum_r, col_sum_nxt;
  logic [ROW_W-1:0] row_sum_r, row_sum_nxt;
  logic             seen_letter_r, seen_letter_nxt;
  logic             seen_digit_r, seen_digit_nxt;
  logic             bad_r, bad_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic             out_ok_r, out_ok_nxt;

  logic             slot_free;
  logic [19:0]      col_acc;
  logic [24:0]      row_acc;
  logic [COL_W-1:0] col_upd;
  logic [ROW_W-1:0] row_upd;
  logic [ROW_W-1:0] rl;
  logic [COL_W-1:0] cl;
  logic             ok;

  assign slot_free = !out_valid_r || !out_stall;
  assign q_pop     = !q_status.empty && (!head.last || slot_free);

  // x26 = x16 + x8 + x2, x10 = x8 + x2
  assign col_acc = (20'(col_sum_r) << 4) + (20'(col_sum_r) << 3) + (20'(col_sum_r) << 1)
                 + 20'(head.value);
  assign row_acc = (25'(row_sum_r) << 3) + (25'(row_sum_r) << 1) + 25'(head.value);
  assign col_upd = (col_acc > 20'(COL_SAT)) ? COL_SAT : col_acc[COL_W-1:0];
  assign row_upd = (row_acc > 25'(ROW_SAT)) ? ROW_SAT : row_acc[ROW_W-1:0];

  assign rl = (row_limit > ROW_MAX_LIMIT) ? ROW_MAX_LIMIT : row_limit;
  assign cl = (column_limit > COL_MAX_LIMIT) ? COL_MAX_LIMIT : column_limit;

  always_comb begin
    row_phase_nxt   = row_phase_r;
    col_sum_nxt     = col_sum_r;
    row_sum_nxt     = row_sum_r;
    seen_letter_nxt = seen_letter_r;
    seen_digit_nxt  = seen_digit_r;
    bad_nxt         = bad_r;

    if (!row_phase_r) begin
      case (head.cls)
        CLS_NONE, CLS_DOLLAR: begin
        end
        CLS_LETTER: begin
          col_sum_nxt     = col_upd;
          seen_letter_nxt = 1'b1;
        end
        CLS_DIGIT: begin
          // first digit or other non-letter, non-dollar character ends the column phase
          row_phase_nxt  = 1'b1;
          bad_nxt        = bad_r || !seen_letter_r;
          row_sum_nxt    = row_upd;
          seen_digit_nxt = 1'b1;
        end
        default: begin
          row_phase_nxt = 1'b1;
          bad_nxt       = 1'b1;
        end
      endcase
    end else begin
      case (head.cls)
        CLS_NONE, CLS_DOLLAR: begin
        end
        CLS_DIGIT: begin
          row_sum_nxt    = row_upd;
          seen_digit_nxt = 1'b1;
        end
        default: begin
          bad_nxt = 1'b1;
        end
      endcase
    end

    ok = !bad_nxt && seen_letter_nxt && seen_digit_nxt &&
         (row_sum_nxt != '0) && (row_sum_nxt <= rl) &&
         (col_sum_nxt != '0) && (col_sum_nxt <= cl);

    out_valid_nxt = out_valid_r && out_stall;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_ok_nxt    = out_ok_r;

    if (q_pop && head.last) begin
      out_valid_nxt   = 1'b1;
      out_row_nxt     = ok ? row_sum_nxt : '0;
      out_col_nxt     = ok ? col_sum_nxt : '0;
      out_ok_nxt      = ok;
      row_phase_nxt   = 1'b0;
      col_sum_nxt     = '0;
      row_sum_nxt     = '0;
      seen_letter_nxt = 1'b0;
      seen_digit_nxt  = 1'b0;
      bad_nxt         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_phase_r   <= 1'b0;
      col_sum_r     <= '0;
      row_sum_r     <= '0;
      seen_letter_r <= 1'b0;
      seen_digit_r  <= 1'b0;
      bad_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        row_phase_r   <= row_phase_nxt;
        col_sum_r     <= col_sum_nxt;
        row_sum_r     <= row_sum_nxt;
        seen_letter_r <= seen_letter_nxt;
        seen_digit_r  <= seen_digit_nxt;
        bad_r         <= bad_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_row_r <= out_row_nxt;
    out_col_r <= out_col_nxt;
    out_ok_r  <= out_ok_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_row_number    = out_row_r;
  assign out_column_number = out_col_r;
  assign out_is_valid      = out_ok_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ok_r |-> (out_row_r == '0) && (out_col_r == '0))
    else $error("invalid result carries nonzero fields");

  a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ok_r |-> (out_row_r != '0) && (out_row_r <= ROW_MAX_LIMIT) &&
                                (out_col_r != '0) && (out_col_r <= COL_MAX_LIMIT))
    else $error("valid result out of range");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && head.last |=> !row_phase_r && (col_sum_r == '0) && (row_sum_r == '0) &&
                           !bad_r && !seen_letter_r && !seen_digit_r)
    else $error("parse state not cleared after last word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !(q_pop && head.last))
    else $error("result taken into a busy output register");

endmodule

// ===== rtl/core/cell_reference_parser_core.sv =====
// ----------------------------------------------------------------------------
// cell_reference_parser_core: A1-style cell reference parser
// A last word's result is registered in the result register when the back
// pops it from the queue, which it does only once that register is free.
// Throughput: one character word per cycle while the queue is not full
// (classify in front, x26 / x10 multiply-add and limit check in back).
// Reset (rst_n low, synchronous): queue empty, parse state cleared, no
// result pending, row_limit = 1048576, column_limit = 16384.
// ----------------------------------------------------------------------------
module cell_reference_parser_core import crp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,

  // input channel: one character word per handshake
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_char_code,
  input  logic             in_char_present,
  input  logic             in_last_char,

  // result channel: one word per reference
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ROW_W-1:0] out_row_number,
  output logic [COL_W-1:0] out_column_number,
  output logic             out_is_valid,

  // APB configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // --------------------------------------------------------------------------
  // Configuration registers. Word index is paddr[2]; low address bits are
  // ignored. Write only while no word is in flight.
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0] row_limit_r, row_limit_nxt;
  logic [COL_W-1:0] col_limit_r, col_limit_nxt;
  logic             cfg_wr;
  logic             cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    row_limit_nxt = row_limit_r;
    col_limit_nxt = col_limit_r;
    if (cfg_wr) begin
      case (cfg_sel)
        REG_ROW_LIMIT: row_limit_nxt = pwdata[ROW_W-1:0];
        REG_COL_LIMIT: col_limit_nxt = pwdata[COL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_limit_r <= ROW_MAX_LIMIT;
      col_limit_r <= COL_MAX_LIMIT;
    end else begin
      row_limit_r <= row_limit_nxt;
      col_limit_r <= col_limit_nxt;
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_ROW_LIMIT: prdata = 32'(row_limit_r);
      REG_COL_LIMIT: prdata = 32'(col_limit_r);
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Front: handshake and classification, straight into the queue.
  // --------------------------------------------------------------------------
  queue_status_t q_status;
  logic          q_push;
  logic          q_pop;
  word_t         q_wdata;
  word_t         q_head;

  crp_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .in_char_present (in_char_present),
    .in_last_char    (in_last_char),
    .q_status        (q_status),
    .q_push          (q_push),
    .q_wdata         (q_wdata)
  );

  // --------------------------------------------------------------------------
  // Queue: decouples input stalls from a blocked result register.
  // --------------------------------------------------------------------------
  crp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .head   (q_head),
    .status (q_status)
  );

  // --------------------------------------------------------------------------
  // Back: accumulators, phase tracking, limit check and result register.
  // Non-last words drain even while a result waits; a last word waits for
  // the output register to free up.
  // --------------------------------------------------------------------------
  crp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (q_head),
    .q_status          (q_status),
    .q_pop             (q_pop),
    .row_limit         (row_limit_r),
    .column_limit      (col_limit_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_row_number    (out_row_number),
    .out_column_number (out_column_number),
    .out_is_valid      (out_is_valid)
  );

endmodule
